// File: hdl/tanh_knee_soft_limiter_assert.svh
// Assertion macros for the tanh knee soft limiter.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef TANH_KNEE_SOFT_LIMITER_ASSERT_SVH
`define TANH_KNEE_SOFT_LIMITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TKSL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TKSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tksl_pkg.sv
// Shared types and constants for the tanh knee soft limiter.
// No dependencies; every file of the block but the assertion header uses it.
package tksl_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int CEIL_BITS    = SAMPLE_BITS - 1;
    localparam int FRAC_BITS    = 31;
    localparam int N_BITS       = 5;
    localparam int SERIES_TERMS = 15;
    localparam int POW_CELLS    = (1 << N_BITS) - 1;

    localparam logic [31:0] Q31_ONE     = 32'h8000_0000;
    // exp(-1) in Q31 as the truncated series gives it
    localparam logic [30:0] EXP_NEG_ONE = 31'd790015085;

    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_PASS = 2'd1;
    localparam logic [1:0] MODE_SAT  = 2'd2;
    localparam logic [1:0] MODE_KNEE = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          block_end_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          block_end_out;
    } t_out_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] raw;
        logic [1:0]             mode;
        logic                   block_end;
    } t_side;

endpackage

// File: hdl/tksl_div_cell.sv
// One restoring shift-subtract step of a long division.
// Depends on tksl_pkg for the sideband type.
module tksl_div_cell #(
    parameter int RW = 23,
    parameter int NB = 36
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [RW-1:0]       i_div,
    input  logic [RW-1:0]       i_rem,
    input  logic [NB-1:0]       i_x,
    input  tksl_pkg::t_side     i_side,
    output logic                o_valid,
    output logic [RW-1:0]       o_div,
    output logic [RW-1:0]       o_rem,
    output logic [NB-1:0]       o_x,
    output tksl_pkg::t_side     o_side
);

    logic [RW:0]     w_trial;
    logic            w_ge;
    logic [RW:0]     w_diff;

    logic            r_valid;
    logic [RW-1:0]   r_div;
    logic [RW-1:0]   r_rem;
    logic [NB-1:0]   r_x;
    tksl_pkg::t_side r_side;

    // bring down the next dividend bit; quotient bits enter at the bottom
    assign w_trial = {i_rem, i_x[NB-1]};
    assign w_ge    = w_trial >= {1'b0, i_div};
    assign w_diff  = w_trial - {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= i_div;
            r_rem  <= w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
            r_x    <= {i_x[NB-2:0], w_ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_rem   = r_rem;
    assign o_x     = r_x;
    assign o_side  = r_side;

endmodule

// File: hdl/tksl_series_cell.sv
// One term of the exp(-f) Taylor series, three register stages deep.
// Depends on tksl_pkg for widths and the sideband type.
module tksl_series_cell #(
    parameter int K = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [31:0]                           i_t,
    input  logic [tksl_pkg::FRAC_BITS-1:0]        i_f,
    input  logic signed [33:0]                    i_sum,
    input  logic [tksl_pkg::N_BITS-1:0]           i_n,
    input  tksl_pkg::t_side                       i_side,
    output logic                                  o_valid,
    output logic [31:0]                           o_t,
    output logic [tksl_pkg::FRAC_BITS-1:0]        o_f,
    output logic signed [33:0]                    o_sum,
    output logic [tksl_pkg::N_BITS-1:0]           o_n,
    output tksl_pkg::t_side                       o_side
);

    localparam int          FB       = tksl_pkg::FRAC_BITS;
    localparam int          NBW      = tksl_pkg::N_BITS;
    localparam logic [32:0] RECIP    = 33'((64'd1 << 32) / K);
    localparam logic [31:0] KW       = 32'(K);
    localparam bit          SUBTRACT = (K % 2) == 1;

    logic [62:0]            w_prod1;
    logic [64:0]            w_prod2;
    logic [31:0]            w_qk;
    logic [31:0]            w_rem;
    logic [31:0]            w_q;

    logic                   r1_valid, r2_valid, r3_valid;
    logic [31:0]            r1_p, r2_p, r2_q, r3_t;
    logic [FB-1:0]          r1_f, r2_f, r3_f;
    logic signed [33:0]     r1_sum, r2_sum, r3_sum;
    logic [NBW-1:0]         r1_n, r2_n, r3_n;
    tksl_pkg::t_side        r1_side, r2_side, r3_side;

    assign w_prod1 = {31'b0, i_t} * {32'b0, i_f};
    // floor divide by K: reciprocal estimate is low by at most one
    assign w_prod2 = {33'b0, r1_p} * {32'b0, RECIP};
    assign w_qk    = r2_q * KW;
    assign w_rem   = r2_p - w_qk;
    assign w_q     = (w_rem >= KW) ? (r2_q + 32'd1) : r2_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p    <= w_prod1[62:31];
            r1_f    <= i_f;
            r1_sum  <= i_sum;
            r1_n    <= i_n;
            r1_side <= i_side;

            r2_p    <= r1_p;
            r2_q    <= w_prod2[63:32];
            r2_f    <= r1_f;
            r2_sum  <= r1_sum;
            r2_n    <= r1_n;
            r2_side <= r1_side;

            r3_t    <= w_q;
            r3_sum  <= SUBTRACT ? (r2_sum - $signed({2'b0, w_q}))
                                : (r2_sum + $signed({2'b0, w_q}));
            r3_f    <= r2_f;
            r3_n    <= r2_n;
            r3_side <= r2_side;
        end
    end

    assign o_valid = r3_valid;
    assign o_t     = r3_t;
    assign o_f     = r3_f;
    assign o_sum   = r3_sum;
    assign o_n     = r3_n;
    assign o_side  = r3_side;

endmodule

// File: hdl/tksl_pow_cell.sv
// One conditional multiply by exp(-1) in Q31; applied when its index is below n.
// Depends on tksl_pkg for widths, the constant and the sideband type.
module tksl_pow_cell #(
    parameter int IDX = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [31:0]                    i_e,
    input  logic [tksl_pkg::N_BITS-1:0]    i_n,
    input  tksl_pkg::t_side                i_side,
    output logic                           o_valid,
    output logic [31:0]                    o_e,
    output logic [tksl_pkg::N_BITS-1:0]    o_n,
    output tksl_pkg::t_side                o_side
);

    localparam logic [tksl_pkg::N_BITS-1:0] IDX_W = tksl_pkg::N_BITS'(IDX);

    logic [62:0]                     w_prod;
    logic                            r_valid;
    logic [31:0]                     r_e;
    logic [tksl_pkg::N_BITS-1:0]     r_n;
    tksl_pkg::t_side                 r_side;

    assign w_prod = {31'b0, i_e} * {32'b0, tksl_pkg::EXP_NEG_ONE};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e    <= (i_n > IDX_W) ? w_prod[62:31] : i_e;
            r_n    <= i_n;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_e     = r_e;
    assign o_n     = r_n;
    assign o_side  = r_side;

endmodule

// File: hdl/tanh_knee_soft_limiter.sv
// Soft limiter with a tanh knee for signed Q1.23 audio samples.
// Usage:
//   Input channel i_in_valid / o_in_ready carries i_in_data (sample, block end).
//   Output channel o_out_valid / i_out_ready carries o_out_data.
//   The ceiling register is written through i_cfg_we / i_cfg_wdata; write it
//   only while no sample is in flight.
// Pipeline:
//   One sample per cycle unless the receiver stalls. Each sample passes one front
//   stage loaded at the transfer edge, 36 division cells for the knee ratio,
//   45 stages for the 15 series terms, 31 exp(-1) multiply cells, 23 division
//   cells for the final quotient, then the output register.
// Reset clears all valid bits and sets the ceiling to full scale.
// When the receiver stalls, a result parks in the output register; one more
// lands in a skid register, and while that is full the whole chain holds and
// o_in_ready is low.
// Depends on tksl_pkg, the cell modules and the assertion macro header.
`include "tanh_knee_soft_limiter_assert.svh"

module tanh_knee_soft_limiter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  tksl_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output tksl_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [tksl_pkg::CEIL_BITS-1:0]        i_cfg_wdata
);

    localparam int W    = tksl_pkg::SAMPLE_BITS;
    localparam int CW   = tksl_pkg::CEIL_BITS;
    localparam int FB   = tksl_pkg::FRAC_BITS;
    localparam int NBW  = tksl_pkg::N_BITS;
    localparam int QA   = NBW + FB;
    localparam int NT   = tksl_pkg::SERIES_TERMS;
    localparam int NP   = tksl_pkg::POW_CELLS;
    localparam int DRW  = 33;

    logic                   w_en;
    logic [CW-1:0]          r_ceiling;

    // front stage
    logic [W-1:0]           w_raw;
    logic                   w_neg;
    logic [W-1:0]           w_mag;
    logic                   w_pass;
    logic [W+1:0]           w_d;
    logic                   w_sat;
    logic [1:0]             w_mode;
    tksl_pkg::t_side        w_side_in;

    // knee ratio division chain
    logic                   a_v    [0:QA];
    logic [CW-1:0]          a_div  [0:QA];
    logic [CW-1:0]          a_rem  [0:QA];
    logic [QA-1:0]          a_x    [0:QA];
    tksl_pkg::t_side        a_side [0:QA];

    // series chain
    logic                   s_v    [0:NT];
    logic [31:0]            s_t    [0:NT];
    logic [FB-1:0]          s_f    [0:NT];
    logic signed [33:0]     s_sum  [0:NT];
    logic [NBW-1:0]         s_n    [0:NT];
    tksl_pkg::t_side        s_side [0:NT];

    // exp(-1) power chain
    logic                   p_v    [0:NP];
    logic [31:0]            p_e    [0:NP];
    logic [NBW-1:0]         p_n    [0:NP];
    tksl_pkg::t_side        p_side [0:NP];

    // final division chain
    logic [DRW-1:0]         w_den;
    logic [CW+31:0]         w_num;
    logic                   b_v    [0:CW];
    logic [DRW-1:0]         b_div  [0:CW];
    logic [DRW-1:0]         b_rem  [0:CW];
    logic [CW-1:0]          b_x    [0:CW];
    tksl_pkg::t_side        b_side [0:CW];

    // result and output buffer
    logic [W-1:0]           w_omag;
    logic [W-1:0]           w_res;
    tksl_pkg::t_out_item    w_push_item;
    logic                   w_push;
    logic                   w_take;
    logic                   r_ov;
    logic                   r_sv;
    tksl_pkg::t_out_item    r_out;
    tksl_pkg::t_out_item    r_skid;

    assign w_en       = !r_sv;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= '1;
        end else if (i_cfg_we) begin
            r_ceiling <= i_cfg_wdata;
        end
    end

    // classify: silence, pass-through, saturated, or knee
    assign w_raw  = i_in_data.sample_in;
    assign w_neg  = w_raw[W-1];
    assign w_mag  = w_neg ? (~w_raw + 1'b1) : w_raw;
    assign w_pass = {w_mag, 1'b0} <= {2'b0, r_ceiling};
    assign w_d    = {w_mag, 2'b0} - {2'b0, r_ceiling, 1'b0};
    assign w_sat  = {2'b0, w_d} >= {r_ceiling, {NBW{1'b0}}};

    always_comb begin
        if (r_ceiling == '0) begin
            w_mode = tksl_pkg::MODE_ZERO;
        end else if (w_pass) begin
            w_mode = tksl_pkg::MODE_PASS;
        end else if (w_sat) begin
            w_mode = tksl_pkg::MODE_SAT;
        end else begin
            w_mode = tksl_pkg::MODE_KNEE;
        end
    end

    assign w_side_in.raw       = w_raw;
    assign w_side_in.mode      = w_mode;
    assign w_side_in.block_end = i_in_data.block_end_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            a_v[0] <= 1'b0;
        end else if (w_en) begin
            a_v[0] <= i_in_valid;
        end
    end

    // d < 32*C, so its top bits already form a remainder below C
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            a_div[0]  <= r_ceiling;
            a_rem[0]  <= CW'(w_d >> NBW);
            a_x[0]    <= {w_d[NBW-1:0], {FB{1'b0}}};
            a_side[0] <= w_side_in;
        end
    end

    for (genvar i = 0; i < QA; i++) begin : g_div_a
        tksl_div_cell #(.RW(CW), .NB(QA)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (a_v[i]),
            .i_div   (a_div[i]),
            .i_rem   (a_rem[i]),
            .i_x     (a_x[i]),
            .i_side  (a_side[i]),
            .o_valid (a_v[i+1]),
            .o_div   (a_div[i+1]),
            .o_rem   (a_rem[i+1]),
            .o_x     (a_x[i+1]),
            .o_side  (a_side[i+1])
        );
    end

    assign s_v[0]    = a_v[QA];
    assign s_t[0]    = tksl_pkg::Q31_ONE;
    assign s_f[0]    = a_x[QA][FB-1:0];
    assign s_sum[0]  = $signed({2'b0, tksl_pkg::Q31_ONE});
    assign s_n[0]    = a_x[QA][QA-1:FB];
    assign s_side[0] = a_side[QA];

    for (genvar k = 0; k < NT; k++) begin : g_series
        tksl_series_cell #(.K(k + 1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (s_v[k]),
            .i_t     (s_t[k]),
            .i_f     (s_f[k]),
            .i_sum   (s_sum[k]),
            .i_n     (s_n[k]),
            .i_side  (s_side[k]),
            .o_valid (s_v[k+1]),
            .o_t     (s_t[k+1]),
            .o_f     (s_f[k+1]),
            .o_sum   (s_sum[k+1]),
            .o_n     (s_n[k+1]),
            .o_side  (s_side[k+1])
        );
    end

    // clamp the series sum to [0, 1.0]
    always_comb begin
        if (s_sum[NT][33]) begin
            p_e[0] = '0;
        end else if (s_sum[NT] > $signed({2'b0, tksl_pkg::Q31_ONE})) begin
            p_e[0] = tksl_pkg::Q31_ONE;
        end else begin
            p_e[0] = s_sum[NT][31:0];
        end
    end

    assign p_v[0]    = s_v[NT];
    assign p_n[0]    = s_n[NT];
    assign p_side[0] = s_side[NT];

    for (genvar i = 0; i < NP; i++) begin : g_pow
        tksl_pow_cell #(.IDX(i)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (p_v[i]),
            .i_e     (p_e[i]),
            .i_n     (p_n[i]),
            .i_side  (p_side[i]),
            .o_valid (p_v[i+1]),
            .o_e     (p_e[i+1]),
            .o_n     (p_n[i+1]),
            .o_side  (p_side[i+1])
        );
    end

    // y = round(C / (1 + E)); numerator top bits stay below the divisor
    assign w_den     = {1'b0, tksl_pkg::Q31_ONE} + {1'b0, p_e[NP]};
    assign w_num     = {1'b0, r_ceiling, {FB{1'b0}}} + (CW+32)'(w_den >> 1);
    assign b_v[0]    = p_v[NP];
    assign b_div[0]  = w_den;
    assign b_rem[0]  = {1'b0, w_num[CW+31:CW]};
    assign b_x[0]    = w_num[CW-1:0];
    assign b_side[0] = p_side[NP];

    for (genvar i = 0; i < CW; i++) begin : g_div_b
        tksl_div_cell #(.RW(DRW), .NB(CW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (b_v[i]),
            .i_div   (b_div[i]),
            .i_rem   (b_rem[i]),
            .i_x     (b_x[i]),
            .i_side  (b_side[i]),
            .o_valid (b_v[i+1]),
            .o_div   (b_div[i+1]),
            .o_rem   (b_rem[i+1]),
            .o_x     (b_x[i+1]),
            .o_side  (b_side[i+1])
        );
    end

    assign w_omag = (b_side[CW].mode == tksl_pkg::MODE_SAT) ? {1'b0, r_ceiling}
                                                            : {1'b0, b_x[CW]};

    always_comb begin
        case (b_side[CW].mode)
            tksl_pkg::MODE_ZERO: w_res = '0;
            tksl_pkg::MODE_PASS: w_res = b_side[CW].raw;
            default:             w_res = b_side[CW].raw[W-1] ? (~w_omag + 1'b1) : w_omag;
        endcase
    end

    assign w_push_item.sample_out    = w_res;
    assign w_push_item.block_end_out = b_side[CW].block_end;
    assign w_push                    = w_en && b_v[CW];
    assign w_take                    = r_ov && i_out_ready;

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (w_take || !r_ov) begin
            r_ov <= r_sv || w_push;
            r_sv <= 1'b0;
        end else if (w_push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take || !r_ov) begin
            r_out <= r_sv ? r_skid : w_push_item;
        end else if (w_push) begin
            r_skid <= w_push_item;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    `TKSL_ASSERT_NOW(a_skid_needs_out, r_sv, r_ov, "skid full while output register empty")
    `TKSL_ASSERT_NOW(a_stall_only_when_backed, !o_in_ready, o_out_valid, "input stalled with no result pending")
    `TKSL_ASSERT_NEXT(a_blocked_push_parks, (r_ov && !i_out_ready && b_v[CW] && w_en), r_sv, "result arriving at a stalled output was not parked")

endmodule
